// ----- rtl/nsbe_pkg.sv -----
// Shared types, constants and helpers for the natural spline basis evaluator.
`timescale 1ns / 1ps

package nsbe_pkg;

  // Default knot count and the widest index the sequencer ever needs (up to 16 knots)
  localparam int unsigned NUM_KNOTS_DEF = 8;
  localparam int unsigned KIDX_W        = 4;
  localparam int unsigned CADDR_W       = 8;

  // Fixed-point widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned VAL_W  = 48;
  localparam int unsigned MUL_W  = 34;

  localparam logic signed [VAL_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] MIN48 = 48'sh8000_0000_0000;
  localparam logic signed [79:0]      SAT_HI = 80'sh7FFF_FFFF_FFFF;
  localparam logic signed [79:0]      SAT_LO = -80'sh8000_0000_0000;

  typedef enum logic [1:0] {
    OP_KNOT = 2'd0,
    OP_COEF = 2'd1,
    OP_EVAL = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KRD,
    ST_KE,
    ST_CM1,
    ST_CM2,
    ST_CM3,
    ST_CM4,
    ST_DIV_CHK,
    ST_DIV_WAIT,
    ST_DSTORE,
    ST_PRD,
    ST_PM1,
    ST_PM2,
    ST_PACC,
    ST_PROW,
    ST_EMIT
  } st_e;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_LOAD_KNOT,
    UOP_LOAD_COEF,
    UOP_START,
    UOP_CUBE_E,
    UOP_CM1,
    UOP_CM2,
    UOP_CM3,
    UOP_CM4,
    UOP_DIV_CHK,
    UOP_DIV_WAIT,
    UOP_DSTORE,
    UOP_PM1,
    UOP_PM2,
    UOP_PACC,
    UOP_PROW
  } uop_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [2:0]              row_index;
    logic [2:0]              column_index;
    logic signed [DATA_W-1:0] load_value;
    logic signed [DATA_W-1:0] point;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]              basis_index;
    logic signed [VAL_W-1:0] basis_value;
    logic                    last_value;
    logic                    error_flag;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    uop_e               uop;
    logic               first;
    logic [KIDX_W-1:0]  kidx;
    logic [KIDX_W-1:0]  jidx;
    logic [KIDX_W-1:0]  nidx;
    logic [KIDX_W-1:0]  oidx;
    logic [CADDR_W-1:0] caddr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic gap_zero;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [VAL_W-1:0] val;
  } sat_t;

  // Clamp to the signed 48-bit range, flag when clamped
  function automatic sat_t sat48(input logic signed [79:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[VAL_W-1:0];
    if (v > SAT_HI) begin
      r.ovf = 1'b1;
      r.val = MAX48;
    end else if (v < SAT_LO) begin
      r.ovf = 1'b1;
      r.val = MIN48;
    end
    return r;
  endfunction

endpackage

// ----- rtl/nsbe_if.sv -----
// Valid/ready stream interfaces for input and result beats.
`timescale 1ns / 1ps

interface nsbe_in_if;
  logic                valid;
  logic                ready;
  nsbe_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nsbe_out_if;
  logic                valid;
  logic                ready;
  nsbe_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/natural_spline_basis_eval.sv -----
// Top level of the natural cubic spline basis evaluator.
`timescale 1ns / 1ps

// Load beats (knot or matrix coefficient) give no result.
// An evaluate beat runs on one shared 34x34 multiplier and a one-bit-per-cycle
// divider: NUM_KNOTS cubes, up to NUM_KNOTS-1 divisions of 63 quotient bits
// each (skipped when a knot gap is zero), and NUM_KNOTS*NUM_KNOTS product
// terms summed row by row. The NUM_KNOTS result beats then follow, one per
// cycle as the sink takes them, all carrying the same error flag, the last one
// marked. A new beat is taken only after the last result beat has gone out.
// Reading a knot or coefficient that was never written gives undefined results.
module natural_spline_basis_eval #(
  parameter int unsigned NUM_KNOTS = nsbe_pkg::NUM_KNOTS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  nsbe_in_if.sink   in_i,
  nsbe_out_if.source out_o
);
  import nsbe_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic signed [47:0] value;
  logic              err;
  logic              out_last;

  nsbe_ctrl #(.NUM_KNOTS(NUM_KNOTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_beat_i   (in_i.data),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_last_o  (out_last),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nsbe_dp #(.NUM_KNOTS(NUM_KNOTS)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .beat_i  (in_i.data),
    .sts_o   (sts),
    .value_o (value),
    .err_o   (err)
  );

  // Result beat
  assign out_o.data.basis_index = 3'(cmd.oidx);
  assign out_o.data.basis_value = value;
  assign out_o.data.last_value  = out_last;
  assign out_o.data.error_flag  = err;

  // Input is never taken while results are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while results pending");

  // After the last result the block is idle again
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.data.last_value) |=> in_i.ready)
    else $error("not idle after last result");

  // Error flag is the same on every result of one evaluation
  a_err_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && $past(out_o.valid)) |-> $stable(out_o.data.error_flag))
    else $error("error flag changed within an evaluation");

  // Results come out in index order
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.data.last_value) |=>
      (out_o.valid && out_o.data.basis_index == 3'($past(out_o.data.basis_index) + 3'd1)))
    else $error("basis index out of sequence");

endmodule

// ----- rtl/nsbe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nsbe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/nsbe_div.sv -----
// Restoring divider on magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps

module nsbe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [62:0] quot_o
);

  localparam int unsigned NW = 63;
  localparam int unsigned DW = 33;
  localparam int unsigned CW = $clog2(NW);

  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          ge;

  // One shift-subtract step
  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    ge      = ~diff[DW+1];
    rem_d   = ge ? diff[DW-1:0] : shifted[DW-1:0];
    quo_d   = {quo_q[NW-2:0], ge};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/nsbe_dp.sv -----
// Datapath: knot and coefficient stores, shared multiplier, divider, accumulators.
`timescale 1ns / 1ps

module nsbe_dp #(
  parameter int unsigned NUM_KNOTS = nsbe_pkg::NUM_KNOTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  nsbe_pkg::cmd_t                       cmd_i,
  input  nsbe_pkg::in_beat_t                   beat_i,
  output nsbe_pkg::sts_t                       sts_o,
  output logic signed [nsbe_pkg::VAL_W-1:0]    value_o,
  output logic                                 err_o
);
  import nsbe_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_KNOTS);
  localparam int unsigned CW    = $clog2(NUM_KNOTS * NUM_KNOTS);

  logic [31:0]              knot_rdata, coef_rdata;
  logic [CW-1:0]            coef_waddr;
  logic signed [31:0]       x_q, t_q, tl_q, m_q;
  logic [31:0]              e_q;
  logic [23:0]              sh_q;
  logic signed [63:0]       part_q;
  logic [46:0]              c_q, cl_q;
  logic signed [47:0]       d_q, dn2_q;
  logic                     neg_q;
  logic signed [55:0]       acc_q;
  logic signed [47:0]       v_q    [NUM_KNOTS];
  logic signed [47:0]       sums_q [NUM_KNOTS];
  logic                     err_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_q;

  logic signed [32:0] diff_xt, gap, gap_n;
  logic [32:0]        gap_mag;
  logic               gap_zero;
  logic [79:0]        cube_sum;
  logic               cube_ovf;
  logic [46:0]        cube_val;
  logic signed [47:0] num, num_n;
  logic [46:0]        num_mag;
  logic               div_done;
  logic [62:0]        quot;
  logic               qpos_ovf, qneg_ovf, d_ovf;
  logic [47:0]        qneg48;
  logic signed [47:0] d_div;
  logic signed [48:0] vd;
  sat_t               vd_sat, term_sat, row_sat;
  logic signed [79:0] term_sum;
  logic signed [47:0] v_sel;
  logic [IDX_W-1:0]   vidx;
  logic               div_start;

  // Stores
  assign coef_waddr = CW'(beat_i.row_index) * CW'(NUM_KNOTS) + CW'(beat_i.column_index);

  nsbe_ram #(.WIDTH(32), .DEPTH(NUM_KNOTS)) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.uop == UOP_LOAD_KNOT),
    .waddr_i (IDX_W'(beat_i.row_index)),
    .wdata_i (beat_i.load_value),
    .raddr_i (cmd_i.kidx[IDX_W-1:0]),
    .rdata_o (knot_rdata)
  );

  nsbe_ram #(.WIDTH(32), .DEPTH(NUM_KNOTS * NUM_KNOTS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.uop == UOP_LOAD_COEF),
    .waddr_i (coef_waddr),
    .wdata_i (beat_i.load_value),
    .raddr_i (cmd_i.caddr[CW-1:0]),
    .rdata_o (coef_rdata)
  );

  assign v_sel = v_q[cmd_i.jidx[IDX_W-1:0]];
  assign vidx  = cmd_i.kidx[IDX_W-1:0] + IDX_W'(2);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.uop)
      UOP_CM1: begin
        mul_a = {2'b00, e_q};
        mul_b = {2'b00, e_q};
      end
      UOP_CM2: begin
        mul_a = {10'b0, prod_q[39:16]};
        mul_b = {2'b00, e_q};
      end
      UOP_CM3: begin
        mul_a = {10'b0, sh_q};
        mul_b = {2'b00, e_q};
      end
      UOP_PM1: begin
        mul_a = {{2{coef_rdata[31]}}, coef_rdata};
        mul_b = {{2{v_sel[47]}}, v_sel[47:16]};
      end
      UOP_PM2: begin
        mul_a = {{2{m_q[31]}}, m_q};
        mul_b = {18'b0, v_sel[15:0]};
      end
      default: ;
    endcase
  end

  // Cube: e = x - t, s = e*e >> 16, c = s*e >> 16 built from two 24-bit halves of s
  always_comb begin
    diff_xt  = {x_q[31], x_q} - {knot_rdata[31], knot_rdata};
    cube_sum = {prod_q[55:0], 24'b0} + {16'b0, part_q};
    cube_ovf = |cube_sum[79:63];
    cube_val = cube_ovf ? 47'h7FFF_FFFF_FFFF : cube_sum[62:16];
  end

  // Divider operands: magnitudes of (c - cL) << 16 and of the knot gap
  always_comb begin
    gap      = {tl_q[31], tl_q} - {t_q[31], t_q};
    gap_n    = -gap;
    gap_zero = (gap == '0);
    gap_mag  = gap[32] ? gap_n : gap;
    num      = {1'b0, c_q} - {1'b0, cl_q};
    num_n    = -num;
    num_mag  = num[47] ? num_n[46:0] : num[46:0];
  end

  assign div_start = (cmd_i.uop == UOP_DIV_CHK) && !gap_zero;

  nsbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({num_mag, 16'b0}),
    .divisor_i  (gap_mag),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Signed, saturated quotient
  always_comb begin
    qpos_ovf = quot > 63'h7FFF_FFFF_FFFF;
    qneg_ovf = quot > 63'h8000_0000_0000;
    qneg48   = -quot[47:0];
    d_ovf    = neg_q ? qneg_ovf : qpos_ovf;
    if (neg_q) begin
      d_div = qneg_ovf ? MIN48 : qneg48;
    end else begin
      d_div = qpos_ovf ? MAX48 : quot[47:0];
    end
  end

  // Basis differences, product terms and row sums
  always_comb begin
    vd       = {d_q[47], d_q} - {dn2_q[47], dn2_q};
    vd_sat   = sat48({{31{vd[48]}}, vd});
    term_sum = {part_q, 16'b0} + {{12{prod_q[67]}}, prod_q};
    term_sat = sat48({{16{term_sum[79]}}, term_sum[79:16]});
    row_sat  = sat48({{24{acc_q[55]}}, acc_q});
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.uop)
      UOP_START: begin
        x_q    <= beat_i.point;
        v_q[0] <= 48'sd65536;
        v_q[1] <= {{16{beat_i.point[31]}}, beat_i.point};
        acc_q  <= '0;
      end
      UOP_CUBE_E: begin
        t_q <= knot_rdata;
        if (cmd_i.first) begin
          tl_q <= knot_rdata;
        end
        e_q <= diff_xt[32] ? '0 : diff_xt[31:0];
      end
      UOP_CM2: sh_q <= prod_q[63:40];
      UOP_CM3: part_q <= prod_q[63:0];
      UOP_CM4: begin
        if (cmd_i.first) begin
          cl_q <= cube_val;
        end else begin
          c_q <= cube_val;
        end
      end
      UOP_DIV_CHK: begin
        neg_q <= num[47] ^ gap[32];
        d_q   <= '0;
      end
      UOP_DIV_WAIT: begin
        if (div_done) begin
          d_q <= d_div;
        end
      end
      UOP_DSTORE: begin
        if (cmd_i.first) begin
          dn2_q <= d_q;
        end else begin
          v_q[vidx] <= vd_sat.val;
        end
      end
      UOP_PM1: m_q <= coef_rdata;
      UOP_PM2: part_q <= prod_q[63:0];
      UOP_PACC: acc_q <= acc_q + {{8{term_sat.val[47]}}, term_sat.val};
      UOP_PROW: begin
        sums_q[cmd_i.nidx[IDX_W-1:0]] <= row_sat.val;
        acc_q                         <= '0;
      end
      default: ;
    endcase
  end

  // Sticky error for the current evaluation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else begin
      case (cmd_i.uop)
        UOP_START:    err_q <= 1'b0;
        UOP_CM4:      if (cube_ovf) err_q <= 1'b1;
        UOP_DIV_CHK:  if (gap_zero) err_q <= 1'b1;
        UOP_DIV_WAIT: if (div_done && d_ovf) err_q <= 1'b1;
        UOP_DSTORE:   if (!cmd_i.first && vd_sat.ovf) err_q <= 1'b1;
        UOP_PACC:     if (term_sat.ovf) err_q <= 1'b1;
        UOP_PROW:     if (row_sat.ovf) err_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign sts_o.gap_zero = gap_zero;
  assign sts_o.div_done = div_done;
  assign value_o        = sums_q[cmd_i.oidx[IDX_W-1:0]];
  assign err_o          = err_q;

endmodule

// ----- rtl/nsbe_ctrl.sv -----
// Controller: sequences loads, cubes, divisions, the matrix product and result beats.
`timescale 1ns / 1ps

module nsbe_ctrl #(
  parameter int unsigned NUM_KNOTS = nsbe_pkg::NUM_KNOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  nsbe_pkg::in_beat_t in_beat_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               out_last_o,
  input  nsbe_pkg::sts_t     sts_i,
  output nsbe_pkg::cmd_t     cmd_o
);
  import nsbe_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_KNOTS);
  localparam int unsigned AW    = $clog2(NUM_KNOTS * NUM_KNOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KNOTS - 1);
  localparam logic [IDX_W-1:0] PEN_IDX  = IDX_W'(NUM_KNOTS - 2);
  localparam logic [IDX_W-1:0] END_IDX  = IDX_W'(NUM_KNOTS - 3);

  st_e              state_q, state_d;
  logic [IDX_W-1:0] k_q, k_d, j_q, j_d, n_q, n_d, o_q, o_d;
  logic [AW-1:0]    a_q, a_d;
  logic             first_q, first_d;
  op_e              op;
  logic             row_ok, col_ok;

  assign op     = op_e'(in_beat_i.operation);
  assign row_ok = 5'(in_beat_i.row_index) < 5'(NUM_KNOTS);
  assign col_ok = 5'(in_beat_i.column_index) < 5'(NUM_KNOTS);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i && op == OP_EVAL) state_d = ST_KRD;
      ST_KRD:      state_d = ST_KE;
      ST_KE:       state_d = ST_CM1;
      ST_CM1:      state_d = ST_CM2;
      ST_CM2:      state_d = ST_CM3;
      ST_CM3:      state_d = ST_CM4;
      ST_CM4:      state_d = first_q ? ST_KRD : ST_DIV_CHK;
      ST_DIV_CHK:  state_d = sts_i.gap_zero ? ST_DSTORE : ST_DIV_WAIT;
      ST_DIV_WAIT: if (sts_i.div_done) state_d = ST_DSTORE;
      ST_DSTORE:   state_d = (k_q == END_IDX) ? ST_PRD : ST_KRD;
      ST_PRD:      state_d = ST_PM1;
      ST_PM1:      state_d = ST_PM2;
      ST_PM2:      state_d = ST_PACC;
      ST_PACC:     state_d = (j_q == LAST_IDX) ? ST_PROW : ST_PRD;
      ST_PROW:     state_d = (n_q == LAST_IDX) ? ST_EMIT : ST_PRD;
      ST_EMIT:     if (out_ready_i && o_q == LAST_IDX) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Loop counters
  always_comb begin
    k_d     = k_q;
    j_d     = j_q;
    n_d     = n_q;
    o_d     = o_q;
    a_d     = a_q;
    first_d = first_q;
    case (state_q)
      ST_IDLE: begin
        k_d     = LAST_IDX;
        first_d = 1'b1;
      end
      ST_CM4: begin
        if (first_q) begin
          first_d = 1'b0;
          k_d     = PEN_IDX;
        end
      end
      ST_DSTORE: begin
        k_d = (k_q == PEN_IDX) ? '0 : k_q + IDX_W'(1);
        a_d = '0;
        j_d = '0;
        n_d = '0;
      end
      ST_PACC: begin
        if (j_q != LAST_IDX) begin
          j_d = j_q + IDX_W'(1);
          a_d = a_q + AW'(1);
        end
      end
      ST_PROW: begin
        n_d = n_q + IDX_W'(1);
        j_d = '0;
        a_d = a_q + AW'(1);
        o_d = '0;
      end
      ST_EMIT: if (out_ready_i) o_d = o_q + IDX_W'(1);
      default: ;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o.uop   = UOP_NONE;
    cmd_o.first = first_q;
    cmd_o.kidx  = KIDX_W'(k_q);
    cmd_o.jidx  = KIDX_W'(j_q);
    cmd_o.nidx  = KIDX_W'(n_q);
    cmd_o.oidx  = KIDX_W'(o_q);
    cmd_o.caddr = CADDR_W'(a_q);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_KNOT: if (row_ok) cmd_o.uop = UOP_LOAD_KNOT;
            OP_COEF: if (row_ok && col_ok) cmd_o.uop = UOP_LOAD_COEF;
            OP_EVAL: cmd_o.uop = UOP_START;
            default: ;
          endcase
        end
      end
      ST_KE:       cmd_o.uop = UOP_CUBE_E;
      ST_CM1:      cmd_o.uop = UOP_CM1;
      ST_CM2:      cmd_o.uop = UOP_CM2;
      ST_CM3:      cmd_o.uop = UOP_CM3;
      ST_CM4:      cmd_o.uop = UOP_CM4;
      ST_DIV_CHK:  cmd_o.uop = UOP_DIV_CHK;
      ST_DIV_WAIT: cmd_o.uop = UOP_DIV_WAIT;
      ST_DSTORE: begin
        cmd_o.uop   = UOP_DSTORE;
        cmd_o.first = (k_q == PEN_IDX);
      end
      ST_PM1:      cmd_o.uop = UOP_PM1;
      ST_PM2:      cmd_o.uop = UOP_PM2;
      ST_PACC:     cmd_o.uop = UOP_PACC;
      ST_PROW:     cmd_o.uop = UOP_PROW;
      default:     cmd_o.uop = UOP_NONE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_last_o  = (o_q == LAST_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      o_q     <= '0;
      a_q     <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      n_q     <= n_d;
      o_q     <= o_d;
      a_q     <= a_d;
      first_q <= first_d;
    end
  end

endmodule
